>>> design/wpm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the wildcard pattern match unit.
// No dependencies; wpm_step, wpm_core and the top level refer to this package.
package wpm_pkg;

   localparam int MAX_PATTERN = 64;
   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int ADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   localparam logic [7:0] STAR_BYTE = 8'h2A;
   localparam logic [7:0] ANY_BYTE = 8'h3F;

   typedef enum logic [1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_APPEND = 2'd1,
      REQ_TEXT   = 2'd2,
      REQ_FINISH = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_WALK
   } seq_state_type;

   // One accepted request beat as handed to the core.
   typedef struct packed {
      logic         accept;
      req_code_type code;
      logic [7:0]   char_value;
   } cmd_type;

   // Core status seen by the top level.
   typedef struct packed {
      logic idle;
      logic match;
      logic overflow;
   } status_type;

endpackage

>>> design/wpm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response sides.
// Depends on nothing; payload widths are fixed by the field definitions.
interface wpm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] char_value;

   modport source (output valid, output req_type, output char_value, input ready);
   modport sink (input valid, input req_type, input char_value, output ready);
endinterface

interface wpm_rsp_if;
   logic valid;
   logic ready;
   logic match;
   logic pattern_overflow;

   modport source (output valid, output match, output pattern_overflow, input ready);
   modport sink (input valid, input match, input pattern_overflow, output ready);
endinterface

>>> design/wpm_step.sv
`timescale 1ns / 1ps
// Shared row-update unit: computes one bit of the new match row per cycle.
// Depends on wpm_pkg for the wildcard byte codes.
module wpm_step (
   input  logic       rebuild,
   input  logic [7:0] pat_byte,
   input  logic [7:0] text_byte,
   input  logic       carry,
   input  logic       old_k,
   input  logic       old_km1,
   output logic       new_bit
);

   logic is_star;
   logic hit;

   assign is_star = (pat_byte == wpm_pkg::STAR_BYTE);
   assign hit = (pat_byte == wpm_pkg::ANY_BYTE) || (pat_byte == text_byte);

   always_comb begin
      if (rebuild) begin
         // Empty text matches a prefix made only of stars.
         new_bit = carry & is_star;
      end else if (is_star) begin
         new_bit = carry | old_k;
      end else begin
         new_bit = hit & old_km1;
      end
   end

endmodule

>>> design/wpm_core.sv
`timescale 1ns / 1ps
// Pattern store, match row and the sequencer that walks the row through wpm_step.
// Depends on wpm_pkg and instantiates wpm_step.
module wpm_core (
   input  logic                 clock,
   input  logic                 reset,
   input  wpm_pkg::cmd_type     cmd,
   output wpm_pkg::status_type  status
);

   logic [7:0]                     pat_mem [wpm_pkg::MAX_PATTERN];
   logic [7:0]                     rd_data_ff;
   logic [wpm_pkg::ADDR_W-1:0]     rd_addr;

   logic [wpm_pkg::LEN_W-1:0]      len_ff;
   logic [wpm_pkg::LEN_W-1:0]      len_in;
   logic                           overflow_ff;
   logic                           overflow_in;
   logic [wpm_pkg::MAX_PATTERN:0]  row_ff;
   logic [wpm_pkg::LEN_W-1:0]      k_ff;
   logic [wpm_pkg::LEN_W-1:0]      k_in;
   logic                           carry_ff;
   logic                           prev_ff;
   logic                           rebuild_ff;
   logic                           rebuild_in;
   logic [7:0]                     text_ff;

   wpm_pkg::seq_state_type         state_ff;
   wpm_pkg::seq_state_type         state_in;

   logic                           start_en;
   logic                           walk_en;
   logic                           walk_last;
   logic                           new_bit;
   logic                           append_ok;

   assign append_ok = cmd.accept && (cmd.code == wpm_pkg::REQ_APPEND) &&
                      (len_ff < wpm_pkg::LEN_W'(wpm_pkg::MAX_PATTERN));
   assign walk_last = (k_ff == len_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wpm_pkg::ST_IDLE: begin
            if (cmd.accept) begin
               state_in = wpm_pkg::ST_START;
            end
         end
         wpm_pkg::ST_START: begin
            state_in = (len_ff == '0) ? wpm_pkg::ST_IDLE : wpm_pkg::ST_WALK;
         end
         wpm_pkg::ST_WALK: begin
            if (walk_last) begin
               state_in = wpm_pkg::ST_IDLE;
            end
         end
         default: state_in = wpm_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      start_en = 1'b0;
      walk_en = 1'b0;
      rd_addr = '0;
      unique case (state_ff)
         wpm_pkg::ST_IDLE: begin
            rd_addr = '0;
         end
         wpm_pkg::ST_START: begin
            start_en = 1'b1;
            rd_addr = '0;
         end
         wpm_pkg::ST_WALK: begin
            walk_en = 1'b1;
            rd_addr = k_ff[wpm_pkg::ADDR_W-1:0];
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   always_comb begin
      len_in = len_ff;
      overflow_in = overflow_ff;
      rebuild_in = rebuild_ff;
      if (cmd.accept) begin
         rebuild_in = (cmd.code != wpm_pkg::REQ_TEXT);
         if (cmd.code == wpm_pkg::REQ_CLEAR) begin
            len_in = '0;
            overflow_in = 1'b0;
         end else if (append_ok) begin
            len_in = len_ff + 1'b1;
         end else if (cmd.code == wpm_pkg::REQ_APPEND) begin
            overflow_in = 1'b1;
         end
      end
   end

   always_comb begin
      k_in = k_ff;
      if (start_en) begin
         k_in = wpm_pkg::LEN_W'(1);
      end else if (walk_en && !walk_last) begin
         k_in = k_ff + 1'b1;
      end
   end

   wpm_step u_step (
      .rebuild   (rebuild_ff),
      .pat_byte  (rd_data_ff),
      .text_byte (text_ff),
      .carry     (carry_ff),
      .old_k     (row_ff[k_ff]),
      .old_km1   (prev_ff),
      .new_bit   (new_bit)
   );

   always_ff @(posedge clock) begin
      if (append_ok) begin
         pat_mem[len_ff[wpm_pkg::ADDR_W-1:0]] <= cmd.char_value;
      end
      rd_data_ff <= pat_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wpm_pkg::ST_IDLE;
         len_ff <= '0;
         overflow_ff <= 1'b0;
         row_ff <= {{wpm_pkg::MAX_PATTERN{1'b0}}, 1'b1};
         k_ff <= '0;
         rebuild_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         overflow_ff <= overflow_in;
         k_ff <= k_in;
         rebuild_ff <= rebuild_in;
         if (start_en) begin
            row_ff[0] <= rebuild_ff;
         end else if (walk_en) begin
            row_ff[k_ff] <= new_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         text_ff <= cmd.char_value;
      end
      if (start_en) begin
         carry_ff <= rebuild_ff;
         prev_ff <= row_ff[0];
      end else if (walk_en) begin
         carry_ff <= new_bit;
         prev_ff <= row_ff[k_ff];
      end
   end

   assign status.idle = (state_ff == wpm_pkg::ST_IDLE);
   assign status.match = row_ff[len_ff];
   assign status.overflow = overflow_ff;

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      walk_en |-> (k_ff != '0) && (k_ff <= len_ff))
      else $error("walk position outside the stored pattern");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= wpm_pkg::LEN_W'(wpm_pkg::MAX_PATTERN))
      else $error("pattern length beyond capacity");

   a_clear_resets: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && (cmd.code == wpm_pkg::REQ_CLEAR) |=> (len_ff == '0) && !overflow_ff)
      else $error("clear did not reset length and overflow");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      !status.idle |-> !cmd.accept)
      else $error("beat accepted while the row walk is running");

endmodule

>>> design/wildcard_pattern_match_unit.sv
`timescale 1ns / 1ps
// Top level of the wildcard pattern match unit: channel handshakes and response register.
// Depends on wpm_pkg, the interfaces in wpm_if.sv, and instantiates wpm_core.

// The unit matches streamed text against a stored glob pattern in which '?' stands
// for any one byte and '*' for any run of bytes, including an empty run. A request
// beat either clears the pattern, appends one pattern byte, feeds one text byte, or
// finishes the text; only a finish beat yields a response beat, carrying the match
// verdict and a flag that says pattern bytes were dropped because the store of
// MAX_PATTERN bytes was full. No request beat is taken until the one before it has
// been worked off: a start state primes the single read port of the pattern memory,
// then the match row is walked one pattern position per cycle through a single
// shared update unit fed by that read port.
// A pattern beat that arrives in the middle of a text discards that text, and a
// finish beat also restarts matching for a fresh text against the same pattern.
// Every request beat is held off while an earlier response still waits to be taken.
module wildcard_pattern_match_unit (
   input  logic       clock,
   input  logic       reset,
   wpm_req_if.sink    req_chan,
   wpm_rsp_if.source  rsp_chan
);

   wpm_pkg::cmd_type    cmd;
   wpm_pkg::status_type status;

   logic req_ready;
   logic req_accept;
   logic finish_accept;

   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic rsp_match_ff;
   logic rsp_overflow_ff;

   // The core must be idle, and the response register must be free or draining,
   // so a finish beat always has a place to put its verdict.
   assign req_ready = status.idle && (!rsp_valid_ff || rsp_chan.ready);
   assign req_accept = req_chan.valid && req_ready;
   assign finish_accept = req_accept &&
                          (wpm_pkg::req_code_type'(req_chan.req_type) == wpm_pkg::REQ_FINISH);

   assign req_chan.ready = req_ready;

   assign cmd.accept = req_accept;
   assign cmd.code = wpm_pkg::req_code_type'(req_chan.req_type);
   assign cmd.char_value = req_chan.char_value;

   wpm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The verdict is sampled from the row as it stands before the finish beat
   // triggers the rebuild for the next text.
   always_ff @(posedge clock) begin
      if (finish_accept) begin
         rsp_match_ff <= status.match;
         rsp_overflow_ff <= status.overflow;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.match = rsp_match_ff;
   assign rsp_chan.pattern_overflow = rsp_overflow_ff;

   a_finish_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      finish_accept |=> rsp_valid_ff)
      else $error("finish beat produced no response beat");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      finish_accept |-> !rsp_valid_ff || rsp_chan.ready)
      else $error("pending response overwritten");

   a_only_finish_responds: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(finish_accept))
      else $error("response beat without a finish beat");

endmodule
